FILE: rtl/sst_pkg.sv
// sst_pkg: shared types, codes and helpers for the supervision session table
// no dependencies; used by the channel interfaces and the top level

package sst_pkg;

	// table depth default and register reset value
	localparam int          MAX_SESSIONS_DEF = 6;
	localparam logic [7:0]  REPORT_CODE_RST  = 8'h02;

	// request codes
	localparam logic [1:0]  REQ_CREATE = 2'd0;
	localparam logic [1:0]  REQ_LOOKUP = 2'd1;
	localparam logic [1:0]  REQ_REPORT = 2'd2;

	// report decoding
	localparam logic [7:0]  MIN_REPORT_LEN   = 8'd4;
	localparam int          MORE_UPDATES_BIT = 7;
	localparam logic [7:0]  ST_NO_SUPPORT    = 8'h00;
	localparam logic [7:0]  ST_WORKING       = 8'h01;
	localparam logic [7:0]  ST_FAIL          = 8'h02;
	localparam logic [7:0]  ST_SUCCESS       = 8'hff;

	// status kind codes
	localparam logic [2:0]  KIND_NO_SUPPORT = 3'd0;
	localparam logic [2:0]  KIND_WORKING    = 3'd1;
	localparam logic [2:0]  KIND_FAIL       = 3'd2;
	localparam logic [2:0]  KIND_SUCCESS    = 3'd3;
	localparam logic [2:0]  KIND_UNKNOWN    = 3'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] command_class;
		logic [7:0] value_index;
		logic [5:0] query_session;
		logic [7:0] msg_command;
		logic [7:0] msg_flags;
		logic [7:0] msg_status;
		logic [7:0] msg_length;
	} in_item_t;

	typedef struct packed {
		logic [5:0] new_session;
		logic       found;
		logic [7:0] found_index;
		logic [7:0] found_class;
		logic       handled;
		logic       report_success;
		logic       session_closed;
		logic [2:0] status_kind;
	} out_item_t;

	// one stored session
	typedef struct packed {
		logic [5:0] sid;
		logic [7:0] cls;
		logic [7:0] idx;
	} entry_t;

	// map a status byte to its kind
	function automatic logic [2:0] classify(input logic [7:0] st);
		logic [2:0] kind;
		unique case (st)
			ST_NO_SUPPORT: kind = KIND_NO_SUPPORT;
			ST_WORKING:    kind = KIND_WORKING;
			ST_FAIL:       kind = KIND_FAIL;
			ST_SUCCESS:    kind = KIND_SUCCESS;
			default:       kind = KIND_UNKNOWN;
		endcase
		return kind;
	endfunction

endpackage

FILE: rtl/sst_ifs.sv
// sst_in_if / sst_out_if: valid-ready channels for requests and results
// depends on sst_pkg for the payload structs

interface sst_in_if import sst_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface sst_out_if import sst_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/supervision_session_table.sv
// supervision_session_table: ordered session table kept in a synchronous memory
// depends on sst_pkg and the channel interfaces in sst_ifs.sv

// One request is in work at a time; a finished result sits in an output
// register so the next request can be taken while it waits. Entries live in
// a single-port-write memory with registered read data, ordered oldest first
// at address 0. A create appends behind the youngest entry; when the table is
// full the oldest entry is first shifted out. A lookup or a decoded report
// scans the entries oldest first until the first match or the last entry
// held. A short report, a foreign command byte or an undefined request goes
// straight to the result. A report that closes its session then shifts the
// younger entries down. The shift sweep through the memory port sets the
// worst case: a report closing the oldest entry of a full table. A result
// that is not taken holds the next one in S_FINISH until the output register
// frees.

module supervision_session_table import sst_pkg::*; #(
	parameter int MAX_SESSIONS = MAX_SESSIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	sst_in_if.sink      request,
	sst_out_if.source   result
);

	localparam int IDX_W = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
	localparam int CNT_W = $clog2(MAX_SESSIONS + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_SESSIONS);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_APPEND,
		S_FINISH
	} state_t;

	state_t           state_q;
	in_item_t         item_q;
	out_item_t        res_q;
	out_item_t        out_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;
	logic [5:0]       last_id_q;
	logic [7:0]       code_q;
	logic [CNT_W-1:0] k_q;
	logic             pend_s1;
	logic [CNT_W-1:0] pend_k_s1;

	entry_t           mem [MAX_SESSIONS];
	entry_t           rd_data_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic [CNT_W-1:0] nxt_k;
	logic [5:0]       key;
	logic             hit;
	logic             accept;
	logic [5:0]       alloc_id;
	logic             out_load;
	out_item_t        start_res;
	state_t           start_state;

	assign request.ready = (state_q == S_IDLE);
	assign accept        = request.valid && request.ready;
	assign result.valid  = out_valid_q;
	assign result.data   = out_q;

	assign nxt_k    = k_q + ONE_CNT;
	assign alloc_id = last_id_q + 6'd1;
	assign key      = (item_q.req_type == REQ_LOOKUP) ? item_q.query_session
	                                                   : item_q.msg_flags[5:0];
	assign hit      = pend_s1 && (rd_data_q.sid == key);
	assign out_load = (state_q == S_FINISH) && (!out_valid_q || result.ready);

	// first result fields and next state for an incoming request
	always_comb begin
		start_res   = '0;
		start_state = S_FINISH;
		unique case (request.data.req_type)
			REQ_CREATE: begin
				start_res.new_session = alloc_id;
				start_state = (count_q == FULL_CNT) ? S_SHIFT_RD : S_APPEND;
			end
			REQ_LOOKUP: begin
				start_state = S_SEARCH;
			end
			REQ_REPORT: begin
				if (request.data.msg_command == code_q) begin
					start_res.handled = 1'b1;
					if (request.data.msg_length >= MIN_REPORT_LEN) begin
						start_res.status_kind = classify(request.data.msg_status);
						start_state = S_SEARCH;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = k_q[IDX_W-1:0];
		wr_data = rd_data_q;
		unique case (state_q)
			S_SEARCH: begin
				rd_en = !hit && (k_q < count_q);
			end
			S_SHIFT_RD: begin
				rd_en   = (nxt_k < count_q);
				rd_addr = nxt_k[IDX_W-1:0];
			end
			S_SHIFT_WR: begin
				wr_en = 1'b1;
			end
			S_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = count_q[IDX_W-1:0];
				wr_data = '{sid: item_q.query_session, cls: item_q.command_class,
				            idx: item_q.value_index};
				wr_data.sid = res_q.new_session;
			end
			default: begin
			end
		endcase
	end

	// session memory, read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// sequencer, table bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			last_id_q   <= '0;
			code_q      <= REPORT_CODE_RST;
			k_q         <= '0;
			pend_s1     <= 1'b0;
			pend_k_s1   <= '0;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				code_q <= cfg_wr_data;
			end

			// output register: take a finished result, free it after its transfer
			if (out_load) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						item_q  <= request.data;
						res_q   <= start_res;
						k_q     <= '0;
						pend_s1 <= 1'b0;
						state_q <= start_state;
						if (request.data.req_type == REQ_CREATE) begin
							last_id_q <= alloc_id;
						end
					end
				end

				// oldest-first scan, one read issued per cycle
				S_SEARCH: begin
					if (hit) begin
						pend_s1           <= 1'b0;
						res_q.found       <= 1'b1;
						res_q.found_index <= rd_data_q.idx;
						res_q.found_class <= rd_data_q.cls;
						if (item_q.req_type == REQ_REPORT) begin
							res_q.report_success <= (item_q.msg_status == ST_SUCCESS);
							if (!item_q.msg_flags[MORE_UPDATES_BIT]) begin
								res_q.session_closed <= 1'b1;
								k_q     <= pend_k_s1;
								state_q <= S_SHIFT_RD;
							end else begin
								state_q <= S_FINISH;
							end
						end else begin
							state_q <= S_FINISH;
						end
					end else if (k_q < count_q) begin
						pend_s1   <= 1'b1;
						pend_k_s1 <= k_q;
						k_q       <= nxt_k;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= S_FINISH;
						end
					end
				end

				// remove entry k by moving younger entries down
				S_SHIFT_RD: begin
					if (nxt_k < count_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						count_q <= count_q - ONE_CNT;
						state_q <= (item_q.req_type == REQ_CREATE) ? S_APPEND : S_FINISH;
					end
				end

				S_SHIFT_WR: begin
					k_q     <= nxt_k;
					state_q <= S_SHIFT_RD;
				end

				// new session goes behind the youngest entry
				S_APPEND: begin
					count_q <= count_q + ONE_CNT;
					state_q <= S_FINISH;
				end

				S_FINISH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/testbench.sv
// testbench for supervision_session_table: directed rows, a create-and-close run, then random request traffic
// depends on sst_pkg, the channel interfaces in sst_ifs.sv and the table rtl

module testbench;
	import sst_pkg::*;

	localparam int         DEPTH         = MAX_SESSIONS_DEF;
	localparam logic [1:0] REQ_UNDEF     = 2'd3;
	localparam int         SETTLE_CYCLES = 2 * DEPTH + 8;
	localparam int         QUIET_LIMIT   = 4000;
	localparam int         RANDOM_ITEMS  = 65;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	sst_in_if  req_ch();
	sst_out_if res_ch();

	supervision_session_table DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.request     (req_ch),
		.result      (res_ch)
	);

	// predicted table contents, oldest first
	entry_t     tbl_entry [DEPTH];
	int         tbl_count = 0;
	logic [5:0] tbl_last_sid = '0;
	logic [7:0] tbl_report_code = REPORT_CODE_RST;

	out_item_t  pending_replies [$];
	dir_row_t   directed_rows [$];
	int         mismatches = 0;
	int         sent_count = 0;
	int         recv_count = 0;
	int         quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// append one row to the directed table
	function automatic void add_row(in_item_t stim, bit typed, out_item_t want);
		dir_row_t row;
		row.stim  = stim;
		row.typed = typed;
		row.want  = want;
		directed_rows = {directed_rows, row};
	endfunction

	// position of the oldest entry holding sid, or -1
	function automatic int oldest_match(logic [5:0] sid);
		for (int k = 0; k < tbl_count; k++) begin
			if (tbl_entry[k].sid == sid) return k;
		end
		return -1;
	endfunction

	// close the gap left by a removed entry
	function automatic void remove_entry(int pos);
		for (int k = pos; k < tbl_count - 1; k++) begin
			tbl_entry[k] = tbl_entry[k + 1];
		end
		tbl_count--;
	endfunction

	// expected reply for one accepted request; updates the predicted table
	function automatic out_item_t predict_reply(in_item_t r);
		out_item_t o;
		int        hit;
		o = '0;
		case (r.req_type)
			REQ_CREATE: begin
				tbl_last_sid = tbl_last_sid + 6'd1;
				if (tbl_count == DEPTH) remove_entry(0);
				tbl_entry[tbl_count] = {tbl_last_sid, r.command_class, r.value_index};
				tbl_count++;
				o.new_session = tbl_last_sid;
			end
			REQ_LOOKUP: begin
				hit = oldest_match(r.query_session);
				if (hit >= 0) begin
					o.found       = 1'b1;
					o.found_index = tbl_entry[hit].idx;
					o.found_class = tbl_entry[hit].cls;
				end
			end
			REQ_REPORT: begin
				if (r.msg_command == tbl_report_code) begin
					o.handled = 1'b1;
					if (r.msg_length >= MIN_REPORT_LEN) begin
						case (r.msg_status)
							ST_NO_SUPPORT: o.status_kind = KIND_NO_SUPPORT;
							ST_WORKING:    o.status_kind = KIND_WORKING;
							ST_FAIL:       o.status_kind = KIND_FAIL;
							ST_SUCCESS:    o.status_kind = KIND_SUCCESS;
							default:       o.status_kind = KIND_UNKNOWN;
						endcase
						hit = oldest_match(r.msg_flags[5:0]);
						if (hit >= 0) begin
							o.found          = 1'b1;
							o.found_index    = tbl_entry[hit].idx;
							o.found_class    = tbl_entry[hit].cls;
							o.report_success = (r.msg_status == ST_SUCCESS);
							if (!r.msg_flags[MORE_UPDATES_BIT]) begin
								remove_entry(hit);
								o.session_closed = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic in_item_t create_item(logic [7:0] cls, logic [7:0] idx);
		in_item_t r;
		r = '0;
		r.req_type      = REQ_CREATE;
		r.command_class = cls;
		r.value_index   = idx;
		return r;
	endfunction

	function automatic in_item_t lookup_item(logic [5:0] sid);
		in_item_t r;
		r = '0;
		r.req_type      = REQ_LOOKUP;
		r.query_session = sid;
		return r;
	endfunction

	function automatic in_item_t report_item(logic [7:0] cmd, logic [7:0] flags,
			logic [7:0] st, logic [7:0] len);
		in_item_t r;
		r = '0;
		r.req_type    = REQ_REPORT;
		r.msg_command = cmd;
		r.msg_flags   = flags;
		r.msg_status  = st;
		r.msg_length  = len;
		return r;
	endfunction

	function automatic out_item_t reply_item(logic [5:0] sid, logic hit, logic [7:0] idx,
			logic [7:0] cls, logic handled, logic ok, logic closed, logic [2:0] kind);
		return {sid, hit, idx, cls, handled, ok, closed, kind};
	endfunction

	// status byte, biased toward the decoded codes
	function automatic logic [7:0] pick_status();
		case ($urandom_range(0, 4))
			0:       return ST_NO_SUPPORT;
			1:       return ST_WORKING;
			2:       return ST_FAIL;
			3:       return ST_SUCCESS;
			default: return 8'($urandom);
		endcase
	endfunction

	// random request: mostly ids that are held and well-formed reports
	function automatic in_item_t random_request();
		in_item_t   r;
		int         pick;
		logic [5:0] sid;
		r.req_type      = REQ_UNDEF;
		r.command_class = 8'($urandom);
		r.value_index   = 8'($urandom);
		r.query_session = 6'($urandom);
		r.msg_command   = 8'($urandom);
		r.msg_flags     = 8'($urandom);
		r.msg_status    = 8'($urandom);
		r.msg_length    = 8'($urandom);
		if (tbl_count > 0 && $urandom_range(0, 3) != 0)
			sid = tbl_entry[$urandom_range(0, tbl_count - 1)].sid;
		else
			sid = 6'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.req_type = REQ_CREATE;
		end else if (pick < 60) begin
			r.req_type      = REQ_LOOKUP;
			r.query_session = sid;
		end else if (pick < 93) begin
			r.req_type = REQ_REPORT;
			if ($urandom_range(0, 9) != 0) r.msg_command = tbl_report_code;
			r.msg_length     = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(4, 255))
			                                                : 8'($urandom_range(0, 3));
			r.msg_flags[5:0] = sid;
			r.msg_status     = pick_status();
		end
		return r;
	endfunction

	function automatic string show_reply(out_item_t r);
		return $sformatf("sid=%0d found=%0b idx=%02h cls=%02h handled=%0b ok=%0b closed=%0b kind=%0d",
			r.new_session, r.found, r.found_index, r.found_class, r.handled,
			r.report_success, r.session_closed, r.status_kind);
	endfunction

	// offer one request and wait for its transfer; typed rows replace the prediction
	task automatic send_request(in_item_t r, bit typed = 1'b0, out_item_t want = '0);
		int        gap;
		out_item_t pred;
		gap = ((sent_count / 40) % 3 == 2) ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		pred = predict_reply(r);
		if (typed) pred = want;
		pending_replies = {pending_replies, pred};
		sent_count++;
	endtask

	// register write once the table has drained
	task automatic write_report_code(logic [7:0] code);
		req_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= code;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tbl_report_code = code;
	endtask

	// stimulus
	initial begin
		logic [7:0] settings [4];
		in_item_t   undef_req;

		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;

		undef_req          = '0;
		undef_req.req_type = REQ_UNDEF;

		// empty table, then fill past capacity
		add_row(lookup_item(6'd0), 1'b1, '0);
		add_row(report_item(REPORT_CODE_RST, 8'h00, ST_NO_SUPPORT, 8'd4), 1'b1,
			reply_item(6'd0, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(create_item(8'h00, 8'h00), 1'b1,
			reply_item(6'd1, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(create_item(8'hff, 8'hff), 1'b1,
			reply_item(6'd2, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(create_item(8'h5a, 8'ha5), 1'b1,
			reply_item(6'd3, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(create_item(8'ha5, 8'h5a), 1'b1,
			reply_item(6'd4, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(create_item(8'h01, 8'h80), 1'b1,
			reply_item(6'd5, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(create_item(8'h80, 8'h01), 1'b1,
			reply_item(6'd6, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		// full table drops the oldest session
		add_row(create_item(8'h33, 8'hcc), 1'b1,
			reply_item(6'd7, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(lookup_item(6'd1), 1'b1, '0);
		add_row(lookup_item(6'd2), 1'b1,
			reply_item(6'd0, 1'b1, 8'hff, 8'hff, 1'b0, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(lookup_item(6'h3f), 1'b1, '0);
		// short report, foreign command byte, undefined request
		add_row(report_item(REPORT_CODE_RST, 8'h02, ST_SUCCESS, 8'd3), 1'b1,
			reply_item(6'd0, 1'b0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, KIND_NO_SUPPORT));
		add_row(report_item(8'hfd, 8'h02, ST_SUCCESS, 8'hff), 1'b1, '0);
		add_row(undef_req, 1'b1, '0);
		// decoded reports: more updates, close, miss, unknown status
		add_row(report_item(REPORT_CODE_RST, 8'h82, ST_SUCCESS, 8'hff), 1'b0, '0);
		add_row(report_item(REPORT_CODE_RST, 8'h03, ST_WORKING, 8'd4), 1'b0, '0);
		add_row(report_item(REPORT_CODE_RST, 8'h3f, ST_FAIL, 8'd5), 1'b0, '0);
		add_row(report_item(REPORT_CODE_RST, 8'h04, 8'h7f, 8'd200), 1'b0, '0);
		add_row(lookup_item(6'd3), 1'b0, '0);
		add_row(report_item(REPORT_CODE_RST, 8'hc7, ST_SUCCESS, 8'd4), 1'b0, '0);
		add_row(report_item(REPORT_CODE_RST, 8'h02, ST_SUCCESS, 8'd4), 1'b0, '0);
		add_row(lookup_item(6'd7), 1'b0, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		// create then close the newest, long enough for ids to wrap onto held ones
		for (int k = 0; k < 66; k++) begin
			send_request(create_item(8'($urandom), 8'($urandom)));
			send_request(report_item(tbl_report_code,
				{1'b0, 1'($urandom), tbl_last_sid}, pick_status(), 8'($urandom_range(4, 255))));
			if (k % 6 == 0 && tbl_count > 0) send_request(lookup_item(tbl_entry[0].sid));
		end

		// random traffic under several report codes, extremes first
		settings[0] = 8'hff;
		settings[1] = 8'h00;
		settings[2] = 8'($urandom);
		settings[3] = REPORT_CODE_RST;
		foreach (settings[s]) begin
			write_report_code(settings[s]);
			repeat (RANDOM_ITEMS) send_request(random_request());
		end

		req_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stalls, calm stretches and two long hold-offs
	initial begin
		int        hold;
		out_item_t want;
		out_item_t got;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = ((recv_count / 35) % 3 == 1) ? 0 : $urandom_range(0, 6);
			if (recv_count == 60 || recv_count == 250) hold = 80;
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			got = res_ch.data;
			recv_count++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: %s", show_reply(got));
			end else begin
				want = pending_replies[0];
				pending_replies.delete(0);
				if (got.new_session !== want.new_session || got.found !== want.found ||
						got.found_index !== want.found_index ||
						got.found_class !== want.found_class || got.handled !== want.handled ||
						got.report_success !== want.report_success ||
						got.session_closed !== want.session_closed ||
						got.status_kind !== want.status_kind) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result %0d expected: %s", recv_count, show_reply(want));
						$display("result %0d actual:   %s", recv_count, show_reply(got));
					end
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
